@@ sv/iirsc_pkg.sv @@
// Shared types, section table and microprogram for the IIR section cascade.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package iirsc_pkg;

  localparam int SampleInW  = 12;
  localparam int SampleOutW = 17;
  localparam int DataW      = 32;
  localparam int TableSects = 8;
  localparam int SectIdxW   = 3;
  localparam int DelaySlots = 7;
  localparam int SlotW      = 3;
  localparam int PcW        = 4;

  typedef enum logic [1:0] {
    KIND_GAIN,
    KIND_FIRST,
    KIND_BIQUAD
  } kind_e;

  typedef struct packed {
    kind_e                    kind;
    logic signed [DataW-1:0]  b1;    // gain value for gain sections
    logic signed [DataW-1:0]  a1;
    logic signed [DataW-1:0]  a2;
    logic [SlotW-1:0]         slot;
  } stage_t;

  // Microcode fields
  typedef enum logic [1:0] {RD_NONE, RD_D0, RD_D1} rd_e;
  typedef enum logic [1:0] {MA_X, MA_D0, MA_D1} mula_e;
  typedef enum logic [1:0] {CF_B1, CF_A1, CF_A2} coef_e;
  typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_e;
  typedef enum logic [1:0] {X_HOLD, X_GAIN, X_BIQ, X_FIRST} xop_e;
  typedef enum logic [1:0] {WR_NONE, WR_D1_FROM_D0, WR_D0_FROM_W} wr_e;
  typedef enum logic [1:0] {SEQ_NEXT, SEQ_SECTION, SEQ_EMIT} seq_e;

  typedef struct packed {
    rd_e   rd;
    logic  mul_en;
    mula_e mula;
    coef_e coef;
    acc_e  acc;
    logic  w_sub;
    xop_e  xop;
    wr_e   wr;
    seq_e  seq;
  } ucode_t;

  typedef struct packed {
    logic                start;
    ucode_t              uc;
    logic [SectIdxW-1:0] sec;
  } dp_ctrl_t;

  localparam ucode_t UC_NOP = '{
    rd: RD_NONE, mul_en: 1'b0, mula: MA_X, coef: CF_B1, acc: ACC_HOLD,
    w_sub: 1'b0, xop: X_HOLD, wr: WR_NONE, seq: SEQ_NEXT
  };

  // Program entry points
  localparam logic [PcW-1:0] PC_GAIN   = 4'd0;
  localparam logic [PcW-1:0] PC_BIQUAD = 4'd3;
  localparam logic [PcW-1:0] PC_FIRST  = 4'd9;
  localparam logic [PcW-1:0] PC_EMIT   = 4'd14;

  // Section table, coefficients in Q.24
  function automatic stage_t stage_rom(input logic [SectIdxW-1:0] idx);
    stage_t st;
    st = '{kind: KIND_GAIN, b1: 32'sd16777216, a1: 32'sd0, a2: 32'sd0, slot: 3'd0};
    unique case (idx)
      3'd0: st.b1 = 32'sd2858333;
      3'd1: st = '{kind: KIND_BIQUAD, b1: 32'sd7735074, a1: -32'sd9796905,
                   a2: 32'sd14629839, slot: 3'd0};
      3'd2: st.b1 = 32'sd3485279;
      3'd3: st = '{kind: KIND_BIQUAD, b1: 32'sd19331578, a1: -32'sd15521948,
                   a2: 32'sd9731211, slot: 3'd2};
      3'd4: st.b1 = 32'sd9857934;
      3'd5: st = '{kind: KIND_FIRST, b1: 32'sd0, a1: -32'sd10359349,
                   a2: 32'sd0, slot: 3'd4};
      default: st.b1 = 32'sd16777216;
    endcase
    return st;
  endfunction

  // Round a Q.24 coefficient to f fractional bits, half toward plus infinity
  function automatic logic signed [DataW-1:0] coef_round(
    input logic signed [DataW-1:0] q24,
    input int f
  );
    logic signed [DataW-1:0] r;
    if (f >= 24) begin
      r = q24;
    end else begin
      r = (q24 + (32'sd1 <<< (23 - f))) >>> (24 - f);
    end
    return r;
  endfunction

  function automatic logic [PcW-1:0] entry_pc(input kind_e kind);
    logic [PcW-1:0] pc;
    unique case (kind)
      KIND_BIQUAD: pc = PC_BIQUAD;
      KIND_FIRST:  pc = PC_FIRST;
      default:     pc = PC_GAIN;
    endcase
    return pc;
  endfunction

  // Microprogram ROM
  function automatic ucode_t ucode_rom(input logic [PcW-1:0] pc);
    ucode_t uc;
    uc = UC_NOP;
    unique case (pc)
      // gain: x = sat(rnd(x * g))
      4'd0: begin uc.mul_en = 1'b1; uc.mula = MA_X; uc.coef = CF_B1; end
      4'd1: uc.acc = ACC_LOAD;
      4'd2: begin uc.xop = X_GAIN; uc.seq = SEQ_SECTION; end
      // biquad
      4'd3: uc.rd = RD_D0;
      4'd4: begin
        uc.rd = RD_D1; uc.mul_en = 1'b1; uc.mula = MA_D0; uc.coef = CF_A1;
      end
      4'd5: begin
        uc.mul_en = 1'b1; uc.mula = MA_D1; uc.coef = CF_A2; uc.acc = ACC_LOAD;
      end
      4'd6: begin
        uc.acc = ACC_ADD; uc.mul_en = 1'b1; uc.mula = MA_D0; uc.coef = CF_B1;
      end
      4'd7: begin uc.w_sub = 1'b1; uc.acc = ACC_LOAD; uc.wr = WR_D1_FROM_D0; end
      4'd8: begin uc.wr = WR_D0_FROM_W; uc.xop = X_BIQ; uc.seq = SEQ_SECTION; end
      // first order
      4'd9:  uc.rd = RD_D0;
      4'd10: begin uc.mul_en = 1'b1; uc.mula = MA_D0; uc.coef = CF_A1; end
      4'd11: uc.acc = ACC_LOAD;
      4'd12: uc.w_sub = 1'b1;
      4'd13: begin uc.wr = WR_D0_FROM_W; uc.xop = X_FIRST; uc.seq = SEQ_SECTION; end
      // hand the result to the output register
      4'd14: uc.seq = SEQ_EMIT;
      default: uc = UC_NOP;
    endcase
    return uc;
  endfunction

endpackage

@@ sv/iirsc_in_if.sv @@
// Input stream channel: valid/ready handshake carrying one converter sample.
// Depends on iirsc_pkg for the sample width.
`timescale 1ns / 1ps

interface iirsc_in_if
  import iirsc_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [SampleInW-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

@@ sv/iirsc_out_if.sv @@
// Output stream channel: valid/ready handshake carrying one filtered sample.
// Depends on iirsc_pkg for the sample width.
`timescale 1ns / 1ps

interface iirsc_out_if
  import iirsc_pkg::*;
;
  logic                         valid;
  logic                         ready;
  logic signed [SampleOutW-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

@@ sv/iir_sos_cascade_lowpass.sv @@
// Fixed low-pass IIR cascade for a 12-bit converter stream. Each input word is one
// unsigned sample; it runs through the first SECTIONS of a table of sections
// (gains, two direct-form-II biquads with numerator 1,b1,1, one first-order
// section, unity gain past the end) and gives one output word: the result in Q.4,
// rounded and saturated to -65536..65535. Coefficients are rounded to
// COEF_FRAC_BITS fractional bits, signals and delays are Q24.8 and saturate to
// 32 bits after every section. One shared multiplier and a single-port delay store
// are stepped by a microprogram: each section in turn, then the hand-over of the
// result, which waits while the output register is still full. The input is ready
// only while the sequencer is idle; a finished word waits in the output register
// while the next sample is taken. Delays reset to zero.
// Depends on iirsc_pkg, iirsc_in_if, iirsc_out_if, iirsc_seq, iirsc_dp and
// iirsc_out_reg.
`timescale 1ns / 1ps

module iir_sos_cascade_lowpass
  import iirsc_pkg::*;
#(
  parameter int SECTIONS       = 7,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  iirsc_in_if.sink    in_i,
  iirsc_out_if.source out_o
);

  logic                         busy;
  logic                         emit;
  logic                         out_free;
  logic                         start;
  dp_ctrl_t                     ctrl;
  logic signed [SampleOutW-1:0] y;

  // Take a new word only while no sample is in flight
  assign in_i.ready = !busy;
  assign start      = in_i.valid && !busy;

  iirsc_seq #(
    .SECTIONS (SECTIONS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .out_free_i (out_free),
    .busy_o     (busy),
    .emit_o     (emit),
    .ctrl_o     (ctrl)
  );

  iirsc_dp #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .sample_i (in_i.sample_in),
    .y_o      (y)
  );

  // Hold the finished word until the sink takes it
  iirsc_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (emit),
    .y_i     (y),
    .ready_i (out_o.ready),
    .valid_o (out_o.valid),
    .free_o  (out_free),
    .y_o     (out_o.sample_out)
  );

endmodule

@@ sv/iirsc_seq.sv @@
// Microcode sequencer: program counter, section counter and control ROM.
// Depends on iirsc_pkg for the program, section table and control types.
`timescale 1ns / 1ps

module iirsc_seq
  import iirsc_pkg::*;
#(
  parameter int SECTIONS = 7
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  logic     out_free_i,
  output logic     busy_o,
  output logic     emit_o,
  output dp_ctrl_t ctrl_o
);

  localparam int KW = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam logic [KW-1:0] KLast = KW'(SECTIONS - 1);

  logic           busy_q, busy_d;
  logic [PcW-1:0] pc_q, pc_d;
  logic [KW-1:0]  k_q, k_d;
  ucode_t         uc;
  stage_t         first_st;
  stage_t         next_st;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= PC_GAIN;
      k_q    <= '0;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
      k_q    <= k_d;
    end
  end

  always_comb begin
    uc       = ucode_rom(pc_q);
    first_st = stage_rom('0);
    next_st  = stage_rom(SectIdxW'(k_q + 1'b1));
    busy_d   = busy_q;
    pc_d     = pc_q;
    k_d      = k_q;
    emit_o   = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      k_d    = '0;
      pc_d   = entry_pc(first_st.kind);
    end else if (busy_q) begin
      unique case (uc.seq)
        SEQ_SECTION: begin
          if (k_q == KLast) begin
            pc_d = PC_EMIT;
          end else begin
            k_d  = k_q + 1'b1;
            pc_d = entry_pc(next_st.kind);
          end
        end
        SEQ_EMIT: begin
          // hold here until the output register can take the word
          if (out_free_i) begin
            emit_o = 1'b1;
            busy_d = 1'b0;
          end
        end
        default: pc_d = pc_q + 1'b1;
      endcase
    end
  end

  assign busy_o       = busy_q;
  assign ctrl_o.start = start_i;
  assign ctrl_o.uc    = busy_q ? uc : UC_NOP;
  assign ctrl_o.sec   = SectIdxW'(k_q);

  a_pc_in_program: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> pc_q <= PC_EMIT)
    else $error("program counter left the microprogram");

  a_k_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> k_q <= KLast)
    else $error("section counter beyond the cascade");

  a_emit_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && uc.seq == SEQ_EMIT && out_free_i && !start_i) |=> !busy_q)
    else $error("sequencer did not go idle after emitting");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("new sample started while busy");

endmodule

@@ sv/iirsc_dp.sv @@
// Shared multiply-accumulate datapath with section delay storage.
// Depends on iirsc_pkg for control types, section table and coefficient rounding.
`timescale 1ns / 1ps

module iirsc_dp
  import iirsc_pkg::*;
#(
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dp_ctrl_t                     ctrl_i,
  input  logic [SampleInW-1:0]         sample_i,
  output logic signed [SampleOutW-1:0] y_o
);

  localparam int F  = COEF_FRAC_BITS;
  localparam int CW = F + 2;
  localparam int PW = DataW + CW;
  localparam int AW = PW + 1;
  localparam int SW = AW + 2;
  localparam logic signed [SW-1:0] MaxV = SW'(32'sh7fffffff);
  localparam logic signed [SW-1:0] MinV = SW'(32'sh80000000);

  function automatic logic signed [SW-1:0] rnd(input logic signed [AW-1:0] v);
    logic signed [SW-1:0] t;
    t = SW'(v) + (SW'(1) <<< (F - 1));
    return t >>> F;
  endfunction

  function automatic logic signed [DataW-1:0] sat32(input logic signed [SW-1:0] v);
    logic signed [DataW-1:0] r;
    if (v > MaxV) begin
      r = 32'sh7fffffff;
    end else if (v < MinV) begin
      r = 32'sh80000000;
    end else begin
      r = v[DataW-1:0];
    end
    return r;
  endfunction

  logic signed [DataW-1:0] mem_q [DelaySlots];
  logic signed [DataW-1:0] x_q, d0_q, d1_q, w_q, mul_a;
  logic signed [PW-1:0]    prod_q;
  logic signed [AW-1:0]    acc_q;
  logic signed [CW-1:0]    coef_v;
  logic signed [DataW-1:0] coef_raw;
  logic [SlotW-1:0]        rd_addr, wr_addr;
  stage_t                  st;
  ucode_t                  uc;
  logic signed [28:0]      r4;

  assign uc = ctrl_i.uc;
  assign st = stage_rom(ctrl_i.sec);

  always_comb begin
    case (uc.coef)
      CF_A1:   coef_raw = st.a1;
      CF_A2:   coef_raw = st.a2;
      default: coef_raw = st.b1;
    endcase
    case (uc.mula)
      MA_D0:   mul_a = d0_q;
      MA_D1:   mul_a = d1_q;
      default: mul_a = x_q;
    endcase
  end

  assign coef_v  = CW'(coef_round(coef_raw, F));
  assign rd_addr = (uc.rd == RD_D1) ? SlotW'(st.slot + 3'd1) : st.slot;
  assign wr_addr = (uc.wr == WR_D1_FROM_D0) ? SlotW'(st.slot + 3'd1) : st.slot;

  // Delay storage, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DelaySlots; i++) begin
        mem_q[i] <= '0;
      end
    end else if (uc.wr != WR_NONE && wr_addr < SlotW'(DelaySlots)) begin
      mem_q[wr_addr] <= (uc.wr == WR_D1_FROM_D0) ? d0_q : w_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (uc.rd == RD_D0) begin
      d0_q <= (rd_addr < SlotW'(DelaySlots)) ? mem_q[rd_addr] : '0;
    end
    if (uc.rd == RD_D1) begin
      d1_q <= (rd_addr < SlotW'(DelaySlots)) ? mem_q[rd_addr] : '0;
    end
    if (uc.mul_en) begin
      prod_q <= PW'(mul_a) * PW'(coef_v);
    end
    case (uc.acc)
      ACC_LOAD: acc_q <= AW'(prod_q);
      ACC_ADD:  acc_q <= acc_q + AW'(prod_q);
      default:  acc_q <= acc_q;
    endcase
    if (uc.w_sub) begin
      w_q <= sat32(SW'(x_q) - rnd(acc_q));
    end
    if (ctrl_i.start) begin
      x_q <= $signed(DataW'({sample_i, 8'h00}));
    end else begin
      case (uc.xop)
        X_GAIN:  x_q <= sat32(rnd(acc_q));
        X_BIQ:   x_q <= sat32(SW'(w_q) + rnd(acc_q) + SW'(d1_q));
        X_FIRST: x_q <= sat32(SW'(w_q) + SW'(d0_q));
        default: x_q <= x_q;
      endcase
    end
  end

  // Round Q.8 to Q.4 and clamp to the output range
  assign r4 = 29'((33'(x_q) + 33'sd8) >>> 4);

  always_comb begin
    if (r4 > 29'sd65535) begin
      y_o = 17'sd65535;
    end else if (r4 < -29'sd65536) begin
      y_o = -17'sd65536;
    end else begin
      y_o = r4[SampleOutW-1:0];
    end
  end

endmodule

@@ sv/iirsc_cascade_top_note.sv @@
// Output staging register between the datapath and the output channel.
// Depends on iirsc_pkg for the sample width.
`timescale 1ns / 1ps

module iirsc_out_reg
  import iirsc_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  logic signed [SampleOutW-1:0] y_i,
  input  logic                         ready_i,
  output logic                         valid_o,
  output logic                         free_o,
  output logic signed [SampleOutW-1:0] y_o
);

  logic                         valid_q;
  logic signed [SampleOutW-1:0] y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      y_q <= y_i;
    end
  end

  assign valid_o = valid_q;
  assign free_o  = !valid_q || ready_i;
  assign y_o     = y_q;

endmodule
